// ===== rtl/core/chroma_key_mask_and_composite_core_assert.svh =====
// Assertion macros for the chroma keyer checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef CHROMA_KEY_MASK_AND_COMPOSITE_CORE_ASSERT_SVH
`define CHROMA_KEY_MASK_AND_COMPOSITE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CKMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ckmc check failed");

// Next-cycle implication, checked outside reset.
`define CKMC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ckmc check failed");

`endif

// ===== rtl/core/ckmc_pkg.sv =====
// Shared types, constants and helpers for the chroma keyer.
// No dependencies.
package ckmc_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 4194304;
    localparam int unsigned SUM_W          = 31;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [7:0]  BALANCE_RESET  = 8'd77;

    typedef enum logic [0:0] {
        REQ_STATS = 1'b0,
        REQ_COMP  = 1'b1
    } t_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel pix;
        logic   key;
    } t_key_res;

    function automatic logic f_dominant(input t_pixel p);
        return (p.green > p.red) && (p.green > p.blue);
    endfunction

endpackage

// ===== rtl/core/ckmc_stats.sv =====
// Statistics accumulator: green excess sum and green pixel count.
// Depends on ckmc_pkg.
module ckmc_stats #(
    parameter int unsigned MAX_PIXELS = ckmc_pkg::MAX_PIXELS_DEF,
    localparam int unsigned CountW    = $clog2(MAX_PIXELS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_upd,
    input  logic                        i_start,
    input  ckmc_pkg::t_pixel            i_pix,
    output logic [ckmc_pkg::SUM_W-1:0]  o_sum,
    output logic [CountW-1:0]           o_count
);

    logic [ckmc_pkg::SUM_W-1:0] r_sum, n_sum, base_sum;
    logic [CountW-1:0]          r_count, n_count, base_count;
    logic [8:0]                 add;
    logic [ckmc_pkg::SUM_W:0]   wide_sum;

    always_comb begin
        base_sum   = i_start ? '0 : r_sum;
        base_count = i_start ? '0 : r_count;
        add        = {1'b0, i_pix.green} + {1'b0, i_pix.green}
                     - {1'b0, i_pix.red} - {1'b0, i_pix.blue};
        wide_sum   = {1'b0, base_sum} + {{(ckmc_pkg::SUM_W - 8){1'b0}}, add};
        n_sum      = r_sum;
        n_count    = r_count;
        if (i_upd) begin
            n_sum   = base_sum;
            n_count = base_count;
            // stop counting once the frame limit is reached
            if (ckmc_pkg::f_dominant(i_pix) && (base_count < CountW'(MAX_PIXELS))) begin
                n_sum   = wide_sum[ckmc_pkg::SUM_W] ? ckmc_pkg::SUM_MAX
                                                    : wide_sum[ckmc_pkg::SUM_W-1:0];
                n_count = base_count + CountW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

// ===== rtl/core/ckmc_keyer.sv =====
// Key decision, despill and composite for one pixel.
// Depends on ckmc_pkg.
module ckmc_keyer #(
    parameter int unsigned MAX_PIXELS = ckmc_pkg::MAX_PIXELS_DEF,
    localparam int unsigned CountW    = $clog2(MAX_PIXELS + 1),
    localparam int unsigned ProdW     = CountW + 10,
    localparam int unsigned CmpW      = (ProdW > ckmc_pkg::SUM_W) ? ProdW : ckmc_pkg::SUM_W
) (
    input  ckmc_pkg::t_pixel            i_fg,
    input  ckmc_pkg::t_pixel            i_bg,
    input  logic [7:0]                  i_limit,
    input  logic [ckmc_pkg::SUM_W-1:0]  i_sum,
    input  logic [CountW-1:0]           i_count,
    output ckmc_pkg::t_key_res          o_res
);

    logic              dom, keyed;
    logic [7:0]        rb, d_r, d_b, spill;
    logic [CountW+1:0] scale;
    logic [ProdW-1:0]  prod_r, prod_b;
    logic [CmpW-1:0]   sum_x;

    always_comb begin
        dom    = ckmc_pkg::f_dominant(i_fg);
        rb     = (i_fg.red > i_fg.blue) ? (i_fg.red - i_fg.blue) : (i_fg.blue - i_fg.red);
        d_r    = i_fg.green - i_fg.red;
        d_b    = i_fg.green - i_fg.blue;
        scale  = {i_count, 2'b00};
        prod_r = ProdW'(scale) * ProdW'(d_r);
        prod_b = ProdW'(scale) * ProdW'(d_b);
        sum_x  = CmpW'(i_sum);
        // both green excesses must beat a quarter of the mean excess
        keyed  = dom && (rb < i_limit)
                 && (CmpW'(prod_r) > sum_x) && (CmpW'(prod_b) > sum_x);
        spill  = (i_fg.red > i_fg.blue) ? i_fg.red : i_fg.blue;

        o_res.key = keyed;
        if (keyed) begin
            o_res.pix = i_bg;
        end else begin
            o_res.pix       = i_fg;
            o_res.pix.green = dom ? spill : i_fg.green;
        end
    end

endmodule

// ===== rtl/core/chroma_key_mask_and_composite_core.sv =====
// Green-screen chroma keyer, one pixel per clock in both passes. A pixel is
// registered on transfer; in the next cycle statistics update or key/composite
// logic runs, and a composite result is loaded into the output register when
// that register is empty or its result is leaving. Statistics pixels produce no
// output. The output register decouples the sides, so input is stalled only
// while a composite pixel waits behind a held result and the output is stalled.
// Write balance_limit only while the block is idle.
module chroma_key_mask_and_composite_core #(
    parameter int unsigned MAX_PIXELS = ckmc_pkg::MAX_PIXELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // pixel input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic       i_frame_start,
    input  logic [7:0] i_fg_red,
    input  logic [7:0] i_fg_green,
    input  logic [7:0] i_fg_blue,
    input  logic [7:0] i_bg_red,
    input  logic [7:0] i_bg_green,
    input  logic [7:0] i_bg_blue,
    // pixel output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic       o_key_bit
);

    localparam int unsigned CountW = $clog2(MAX_PIXELS + 1);

    logic                       r_s1_vld, n_s1_vld;
    ckmc_pkg::t_req             r_s1_req;
    logic                       r_s1_start;
    ckmc_pkg::t_pixel           r_s1_fg, r_s1_bg;
    logic                       r_out_vld, n_out_vld;
    ckmc_pkg::t_key_res         r_out;
    logic [7:0]                 r_limit;
    logic                       in_xfer, s1_adv, out_load, stats_upd;
    logic [ckmc_pkg::SUM_W-1:0] sum;
    logic [CountW-1:0]          count;
    ckmc_pkg::t_key_res         key_res;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        // stats pixels always drain; composites need room at the output
        s1_adv     = r_s1_vld && ((r_s1_req == ckmc_pkg::REQ_STATS)
                                  || !r_out_vld || !i_out_stall);
        o_in_stall = r_s1_vld && !s1_adv;
        in_xfer    = i_in_valid && !o_in_stall;
        out_load   = s1_adv && (r_s1_req == ckmc_pkg::REQ_COMP);
        stats_upd  = s1_adv && (r_s1_req == ckmc_pkg::REQ_STATS);
        n_s1_vld   = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
        n_out_vld  = out_load ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_limit   <= ckmc_pkg::BALANCE_RESET;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_req   <= ckmc_pkg::t_req'(i_req_type);
            r_s1_start <= i_frame_start;
            r_s1_fg    <= '{red: i_fg_red, green: i_fg_green, blue: i_fg_blue};
            r_s1_bg    <= '{red: i_bg_red, green: i_bg_green, blue: i_bg_blue};
        end
        if (out_load) begin
            r_out <= key_res;
        end
    end

    ckmc_stats #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (stats_upd),
        .i_start (r_s1_start),
        .i_pix   (r_s1_fg),
        .o_sum   (sum),
        .o_count (count)
    );

    ckmc_keyer #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_keyer (
        .i_fg    (r_s1_fg),
        .i_bg    (r_s1_bg),
        .i_limit (r_limit),
        .i_sum   (sum),
        .i_count (count),
        .o_res   (key_res)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_red   = r_out.pix.red;
    assign o_out_green = r_out.pix.green;
    assign o_out_blue  = r_out.pix.blue;
    assign o_key_bit   = r_out.key;

endmodule

// ===== rtl/core/ckmc_chk.sv =====
// Port-level checker for the chroma keyer, bound to the top level.
// Depends on chroma_key_mask_and_composite_core_assert.svh.
`include "chroma_key_mask_and_composite_core_assert.svh"

module ckmc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_cfg_ready,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic       o_key_bit
);

    // input backs up only behind a held result
    `CKMC_ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)
    // an unkeyed result never leaves green dominant after despill
    `CKMC_ASSERT_IMP(a_despill, o_out_valid && !o_key_bit, !((o_out_green > o_out_red) && (o_out_green > o_out_blue)))
    `CKMC_ASSERT_IMP(a_cfg_ready, 1'b1, o_cfg_ready)
    `CKMC_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable({o_out_red, o_out_green, o_out_blue, o_key_bit}))

endmodule

bind chroma_key_mask_and_composite_core ckmc_chk u_chk (.*);
